// ===== hdl/wbc_pkg.sv =====
// ----------------------------------------------------------------------------
// wbc_pkg
// Shared widths, codes and types for the wiper bisection level calibrator.
// ----------------------------------------------------------------------------
package wbc_pkg;

  localparam int LEVEL_BITS = 24;
  localparam int WIPER_BITS = 9;
  localparam int CFG_BITS   = WIPER_BITS;
  localparam int FAIL_BITS  = 3;
  localparam int PROD_BITS  = LEVEL_BITS + 7;

  localparam logic [FAIL_BITS-1:0]  FAIL_LIMIT   = FAIL_BITS'(4);
  localparam logic [FAIL_BITS-1:0]  FAIL_MAX     = FAIL_BITS'(7);
  localparam logic [WIPER_BITS-1:0] CEIL_RESET   = WIPER_BITS'(256);

  // command codes
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_FAIL    = 2'd2
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    ST_SEARCH = 2'd0,
    ST_DONE   = 2'd1,
    ST_STOP   = 2'd2,
    ST_IGNORE = 2'd3
  } status_t;

  // register indexes
  typedef enum logic [1:0] {
    REG_CORRELATION = 2'd0,
    REG_FLOOR       = 2'd1,
    REG_CEILING     = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                  correlation_mode;
    logic [WIPER_BITS-1:0] wiper_floor;
    logic [WIPER_BITS-1:0] wiper_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            command;
    logic [LEVEL_BITS-1:0] target_level;
    logic [WIPER_BITS-1:0] start_wiper;
    logic [LEVEL_BITS-1:0] measured_level;
  } item_t;

  typedef struct packed {
    logic [WIPER_BITS-1:0] wiper_code;
    logic                  write_wiper;
    status_t               status;
  } result_t;

  typedef struct packed {
    logic                  busy;
    logic [LEVEL_BITS-1:0] goal_level;
    logic [WIPER_BITS-1:0] wiper_now;
    logic [WIPER_BITS-1:0] wiper_before;
    logic [LEVEL_BITS-1:0] level_before;
    logic                  have_previous;
    logic [WIPER_BITS-1:0] bound_low;
    logic [WIPER_BITS-1:0] bound_high;
    logic [FAIL_BITS-1:0]  fail_count;
    logic                  fail_seen;
  } state_t;

endpackage

// ===== hdl/wbc_if.sv =====
// ----------------------------------------------------------------------------
// wbc_if
// Valid/ready channels for calibrator command words and result words.
// ----------------------------------------------------------------------------
interface wbc_in_if;
  import wbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [LEVEL_BITS-1:0] target_level;
  logic [WIPER_BITS-1:0] start_wiper;
  logic [LEVEL_BITS-1:0] measured_level;

  modport source (output valid, command, target_level, start_wiper, measured_level,
                  input ready);
  modport sink   (input valid, command, target_level, start_wiper, measured_level,
                  output ready);
endinterface

interface wbc_out_if;
  import wbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [WIPER_BITS-1:0] wiper_code;
  logic                  write_wiper;
  logic [1:0]            status;

  modport source (output valid, wiper_code, write_wiper, status, input ready);
  modport sink   (input valid, wiper_code, write_wiper, status, output ready);
endinterface

// ===== hdl/wbc_step.sv =====
// ----------------------------------------------------------------------------
// wbc_step
// One search step: next search state and result word for one command word.
// ----------------------------------------------------------------------------
module wbc_step (
  input  wbc_pkg::state_t  st,
  input  wbc_pkg::cfg_t    cfg,
  input  wbc_pkg::item_t   item,
  output wbc_pkg::state_t  st_next,
  output wbc_pkg::result_t res
);
  import wbc_pkg::*;

  logic [LEVEL_BITS-1:0] dist_now;
  logic [LEVEL_BITS-1:0] dist_before;
  logic [PROD_BITS-1:0]  dist_x100;
  logic                  same_wiper;
  logic                  converged;
  logic                  low_side;
  logic                  go_up;
  logic [WIPER_BITS:0]   mid_sum;
  logic [WIPER_BITS-1:0] mid;
  logic [FAIL_BITS-1:0]  fail_inc;

  // distance of the new level and of the previous level from the goal
  assign dist_now = (item.measured_level >= st.goal_level) ?
                    (item.measured_level - st.goal_level) :
                    (st.goal_level - item.measured_level);
  assign dist_before = (st.level_before >= st.goal_level) ?
                       (st.level_before - st.goal_level) :
                       (st.goal_level - st.level_before);

  // 100 * distance as shifts and adds
  assign dist_x100 = (PROD_BITS'(dist_now) << 6) + (PROD_BITS'(dist_now) << 5) +
                     (PROD_BITS'(dist_now) << 2);

  // convergence: wiper unchanged or within one percent of the goal
  assign same_wiper = st.have_previous && (st.wiper_before == st.wiper_now);
  assign converged  = same_wiper || (dist_x100 <= PROD_BITS'(st.goal_level));

  // search direction from the correlation sense
  assign low_side = (item.measured_level <= st.goal_level);
  assign go_up    = cfg.correlation_mode ? !low_side : low_side;

  // halfway toward the opposite bound, rounding down
  assign mid_sum = {1'b0, st.wiper_now} +
                   {1'b0, (go_up ? st.bound_high : st.bound_low)};
  assign mid     = mid_sum[WIPER_BITS:1];

  // saturating failure count
  assign fail_inc = (st.fail_count == FAIL_MAX) ? st.fail_count :
                    st.fail_count + FAIL_BITS'(1);

  always_comb begin
    st_next         = st;
    res.wiper_code  = st.wiper_now;
    res.write_wiper = 1'b0;
    res.status      = ST_IGNORE;
    unique case (item.command)
      CMD_START: begin
        if (!st.busy) begin
          st_next.goal_level    = item.target_level;
          st_next.wiper_now     = item.start_wiper;
          st_next.wiper_before  = '0;
          st_next.level_before  = '0;
          st_next.have_previous = 1'b0;
          st_next.bound_low     = cfg.wiper_floor;
          st_next.bound_high    = cfg.wiper_ceiling;
          st_next.fail_count    = '0;
          st_next.fail_seen     = 1'b0;
          st_next.busy          = 1'b1;
          res.wiper_code        = item.start_wiper;
          res.status            = ST_SEARCH;
        end
      end
      CMD_MEASURE: begin
        if (st.busy) begin
          // a measurement without a failure in between means the write landed
          st_next.fail_count = st.fail_seen ? st.fail_count : '0;
          st_next.fail_seen  = 1'b0;
          res.write_wiper    = 1'b1;
          if (converged) begin
            if (st.have_previous && (dist_before <= dist_now)) begin
              st_next.wiper_now = st.wiper_before;
            end
            st_next.busy       = 1'b0;
            st_next.fail_count = '0;
            res.wiper_code     = (st.have_previous && (dist_before <= dist_now)) ?
                                 st.wiper_before : st.wiper_now;
            res.status         = ST_DONE;
          end else begin
            st_next.wiper_before  = st.wiper_now;
            st_next.level_before  = item.measured_level;
            st_next.have_previous = 1'b1;
            if (go_up) begin
              st_next.bound_low  = st.wiper_now;
            end else begin
              st_next.bound_high = st.wiper_now;
            end
            st_next.wiper_now = mid;
            res.wiper_code    = mid;
            res.status        = ST_SEARCH;
          end
        end
      end
      CMD_FAIL: begin
        if (st.busy) begin
          st_next.fail_count = fail_inc;
          st_next.fail_seen  = 1'b1;
          if (fail_inc >= FAIL_LIMIT) begin
            st_next.busy = 1'b0;
            res.status   = ST_STOP;
          end else begin
            res.status   = ST_SEARCH;
          end
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

// ===== hdl/wiper_bisection_level_calibrator.sv =====
// ----------------------------------------------------------------------------
// wiper_bisection_level_calibrator
// Bisection search of a potentiometer wiper code toward a target light level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command words: start (target level and initial wiper),
//   measured level at the current wiper, or wiper write failure.
//   out_ch returns exactly one result word per command word: the wiper code
//   to apply next or the final code, a write flag, and a status.
//   cfg_we/cfg_index/cfg_data set correlation sense, floor and ceiling;
//   write them only while no search step is in flight.
// Result path:
//   a word accepted at one edge has its result on out_ch right after that
//   edge; one word per cycle sustained while out_ch.ready is high. The
//   search step is a single pass of combinational logic from the state
//   registers into the result register.
// Reset:
//   rst (synchronous) clears the search state to idle and loads the
//   register defaults; the result register is emptied.
// Stalls:
//   while out_ch.ready is low a held result blocks in_ch.ready; a new word
//   is taken in the same cycle the held result leaves.
// ----------------------------------------------------------------------------
module wiper_bisection_level_calibrator (
  input  logic                           clk,
  input  logic                           rst,
  wbc_in_if.sink                         in_ch,
  wbc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [wbc_pkg::CFG_BITS-1:0]   cfg_data
);
  import wbc_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item;
  result_t step_res;
  result_t res_q;
  logic    out_valid;
  logic    accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.correlation_mode <= 1'b1;
      cfg.wiper_floor      <= '0;
      cfg.wiper_ceiling    <= CEIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CORRELATION: cfg.correlation_mode <= cfg_data[0];
        REG_FLOOR:       cfg.wiper_floor      <= cfg_data[WIPER_BITS-1:0];
        REG_CEILING:     cfg.wiper_ceiling    <= cfg_data[WIPER_BITS-1:0];
        default:         cfg                  <= cfg;
      endcase
    end
  end

  // input word
  assign item.command        = in_ch.command;
  assign item.target_level   = in_ch.target_level;
  assign item.start_wiper    = in_ch.start_wiper;
  assign item.measured_level = in_ch.measured_level;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // search step
  wbc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .res     (step_res)
  );

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.wiper_code  = res_q.wiper_code;
  assign out_ch.write_wiper = res_q.write_wiper;
  assign out_ch.status      = res_q.status;

`ifndef SYNTH
  // an accepted word always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("no result after accepted word");

  // finished results always carry a wiper write
  a_done_writes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_q.status == ST_DONE) |-> res_q.write_wiper)
    else $error("finished result without wiper write");

  // a finished or stopped step leaves the search idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    accept && ((step_res.status == ST_DONE) || (step_res.status == ST_STOP))
    |=> !st.busy)
    else $error("search still busy after end");

  // a running search never holds the failure limit
  a_fail_bound: assert property (@(posedge clk) disable iff (rst)
    st.busy |-> (st.fail_count < FAIL_LIMIT))
    else $error("failure count at limit while busy");
`endif

endmodule

// ===== tb/sv/wbc_search_checker.sv =====
// ----------------------------------------------------------------------------
// wbc_search_checker
// Watches the command and result channels and the register port of the
// wiper bisection level calibrator. It keeps its own copy of the search
// state and registers, predicts one result word per accepted command word,
// and compares every accepted result word field by field in order.
// ----------------------------------------------------------------------------
module wbc_search_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     in_command,
  input  logic [wbc_pkg::LEVEL_BITS-1:0] in_target_level,
  input  logic [wbc_pkg::WIPER_BITS-1:0] in_start_wiper,
  input  logic [wbc_pkg::LEVEL_BITS-1:0] in_measured_level,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [wbc_pkg::WIPER_BITS-1:0] out_wiper_code,
  input  logic                           out_write_wiper,
  input  logic [1:0]                     out_status,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [wbc_pkg::CFG_BITS-1:0]   cfg_data,
  output int                             mismatches,
  output int                             words_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import wbc_pkg::*;

  // mirrored registers and search state
  cfg_t    cal_regs;
  state_t  search;
  result_t results_due[$];

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  function automatic logic [LEVEL_BITS-1:0] level_gap(input logic [LEVEL_BITS-1:0] a,
                                                      input logic [LEVEL_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // halfway point, rounding down
  function automatic logic [WIPER_BITS-1:0] halfway(input logic [WIPER_BITS-1:0] a,
                                                    input logic [WIPER_BITS-1:0] b);
    logic [WIPER_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[WIPER_BITS:1];
  endfunction

  // one search step: updates the mirrored state, returns the result word
  task automatic bisect_step(input logic [1:0] cmd, input logic [LEVEL_BITS-1:0] tgt,
                             input logic [WIPER_BITS-1:0] sw,
                             input logic [LEVEL_BITS-1:0] lvl, output result_t res);
    logic [LEVEL_BITS-1:0] gap_now;
    logic [PROD_BITS-1:0]  scaled;
    logic                  same_wiper;
    logic                  low_side;
    logic                  go_up;
    res.wiper_code  = search.wiper_now;
    res.write_wiper = 1'b0;
    res.status      = ST_IGNORE;
    if (cmd == CMD_START) begin
      // a start while busy is rejected with no state change
      if (!search.busy) begin
        search.goal_level    = tgt;
        search.wiper_now     = sw;
        search.wiper_before  = '0;
        search.level_before  = '0;
        search.have_previous = 1'b0;
        search.bound_low     = cal_regs.wiper_floor;
        search.bound_high    = cal_regs.wiper_ceiling;
        search.fail_count    = '0;
        search.fail_seen     = 1'b0;
        search.busy          = 1'b1;
        res.wiper_code       = sw;
        res.status           = ST_SEARCH;
      end
    end else if (cmd == CMD_MEASURE && search.busy) begin
      gap_now    = level_gap(lvl, search.goal_level);
      scaled     = PROD_BITS'(gap_now) * PROD_BITS'(100);
      same_wiper = search.have_previous && (search.wiper_before == search.wiper_now);
      // a measurement with no failure since the last one means the write took
      if (!search.fail_seen) search.fail_count = '0;
      search.fail_seen = 1'b0;
      if (same_wiper || scaled <= PROD_BITS'(search.goal_level)) begin
        // converged: keep the closer of the last two wipers, ties to the older
        if (search.have_previous &&
            level_gap(search.level_before, search.goal_level) <= gap_now)
          search.wiper_now = search.wiper_before;
        search.busy       = 1'b0;
        search.fail_count = '0;
        res.status        = ST_DONE;
      end else begin
        low_side = (lvl <= search.goal_level);
        go_up    = cal_regs.correlation_mode ? !low_side : low_side;
        search.wiper_before  = search.wiper_now;
        search.level_before  = lvl;
        search.have_previous = 1'b1;
        if (go_up) begin
          search.bound_low = search.wiper_now;
          search.wiper_now = halfway(search.wiper_now, search.bound_high);
        end else begin
          search.bound_high = search.wiper_now;
          search.wiper_now  = halfway(search.wiper_now, search.bound_low);
        end
        res.status = ST_SEARCH;
      end
      res.wiper_code  = search.wiper_now;
      res.write_wiper = 1'b1;
    end else if (cmd == CMD_FAIL && search.busy) begin
      if (search.fail_count < FAIL_MAX) search.fail_count = search.fail_count + 1'b1;
      search.fail_seen = 1'b1;
      if (search.fail_count >= FAIL_LIMIT) begin
        search.busy = 1'b0;
        res.status  = ST_STOP;
      end else begin
        res.status = ST_SEARCH;
      end
    end
  endtask

  // result words leave before this edge's command word is predicted
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      cal_regs.correlation_mode = 1'b1;
      cal_regs.wiper_floor      = '0;
      cal_regs.wiper_ceiling    = CEIL_RESET;
      search                    = '0;
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with none due, wiper_code", '0, out_wiper_code);
        end else begin
          want = results_due.pop_front();
          if (out_wiper_code !== want.wiper_code)
            report_mismatch("wiper_code", want.wiper_code, out_wiper_code);
          if (out_write_wiper !== want.write_wiper)
            report_mismatch("write_wiper", want.write_wiper, out_write_wiper);
          if (out_status !== want.status)
            report_mismatch("status", want.status, out_status);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CORRELATION: cal_regs.correlation_mode = cfg_data[0];
          REG_FLOOR:       cal_regs.wiper_floor      = cfg_data;
          REG_CEILING:     cal_regs.wiper_ceiling    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        bisect_step(in_command, in_target_level, in_start_wiper, in_measured_level, want);
        results_due.push_back(want);
      end
    end
    words_due = results_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the wiper bisection level calibrator with a directed opening and
// then random searches under several register settings and idle patterns;
// the checker beside the block predicts and compares, this module gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_top ();
  timeunit 1ns;
  timeprecision 1ps;
  import wbc_pkg::*;

  localparam logic [1:0]            CMD_UNUSED    = 2'd3;
  localparam logic [1:0]            REG_UNUSED    = 2'd3;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX     = {LEVEL_BITS{1'b1}};
  localparam logic [WIPER_BITS-1:0] WIPER_MAX     = {WIPER_BITS{1'b1}};
  localparam int                    IDLE_LIMIT    = 2000;
  localparam int                    SEGMENTS      = 8;
  localparam int                    SEGMENT_ITEMS = 88;

  typedef enum int {
    MODE_STEADY,
    MODE_SENDER_GAPS,
    MODE_RECEIVER_STALLS,
    MODE_BOTH
  } idle_mode_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  int                  send_pct;
  int                  stall_pct;
  int                  items_sent;
  int                  mismatches;
  int                  words_due;
  int                  quiet_cycles;

  wbc_in_if  in_ch ();
  wbc_out_if out_ch ();

  wiper_bisection_level_calibrator uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wbc_search_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_command        (in_ch.command),
    .in_target_level   (in_ch.target_level),
    .in_start_wiper    (in_ch.start_wiper),
    .in_measured_level (in_ch.measured_level),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_wiper_code    (out_ch.wiper_code),
    .out_write_wiper   (out_ch.write_wiper),
    .out_status        (out_ch.status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .words_due         (words_due)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no word moving on either channel
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("wiper_bisection_level_calibrator verification failed");
    $finish;
  end

  function automatic logic [LEVEL_BITS-1:0] rand_level();
    return LEVEL_BITS'($urandom);
  endfunction

  function automatic logic [WIPER_BITS-1:0] rand_wiper();
    return WIPER_BITS'($urandom);
  endfunction

  task automatic set_mode(input idle_mode_t mode);
    case (mode)
      MODE_STEADY:          begin send_pct = 0;  stall_pct = 0;  end
      MODE_SENDER_GAPS:     begin send_pct = 67; stall_pct = 0;  end
      MODE_RECEIVER_STALLS: begin send_pct = 0;  stall_pct = 67; end
      default:              begin send_pct = 34; stall_pct = 34; end
    endcase
  endtask

  // one command word, entered and left at a falling edge
  task automatic send_word(input logic [1:0] cmd, input logic [LEVEL_BITS-1:0] tgt,
                           input logic [WIPER_BITS-1:0] sw,
                           input logic [LEVEL_BITS-1:0] lvl);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.target_level   <= tgt;
    in_ch.start_wiper    <= sw;
    in_ch.measured_level <= lvl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic start_search(input logic [LEVEL_BITS-1:0] tgt,
                              input logic [WIPER_BITS-1:0] sw);
    send_word(CMD_START, tgt, sw, rand_level());
  endtask

  task automatic measure(input logic [LEVEL_BITS-1:0] lvl);
    send_word(CMD_MEASURE, rand_level(), rand_wiper(), lvl);
  endtask

  task automatic report_fail();
    send_word(CMD_FAIL, rand_level(), rand_wiper(), rand_level());
  endtask

  task automatic wait_drained();
    while (words_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // register settings per segment, extremes first
  task automatic configure(input int seg);
    logic                  corr;
    logic [WIPER_BITS-1:0] lo;
    logic [WIPER_BITS-1:0] hi;
    logic [WIPER_BITS-1:0] swap;
    logic [CFG_BITS-1:0]   corr_word;
    case (seg)
      0: begin corr = 1'b0; lo = '0;        hi = WIPER_MAX; end
      1: begin corr = 1'b1; lo = '0;        hi = WIPER_MAX; end
      2: begin corr = 1'b0; lo = WIPER_MAX; hi = '0;        end
      3: begin corr = 1'b1; lo = rand_wiper(); hi = lo;     end
      default: begin
        corr = 1'($urandom_range(1));
        lo   = rand_wiper();
        hi   = rand_wiper();
        // mostly a proper range, now and then floor above ceiling
        if (lo > hi && $urandom_range(3) != 0) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
      end
    endcase
    corr_word    = rand_wiper();
    corr_word[0] = corr;
    // stop offering the last word before waiting for the block to empty
    in_ch.valid <= 1'b0;
    wait_drained();
    write_reg(REG_CORRELATION, corr_word);
    write_reg(REG_FLOOR, lo);
    write_reg(REG_CEILING, hi);
    if (seg == 4) write_reg(REG_UNUSED, rand_wiper());
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // a start followed by a run of measurements, failures and odd words
  task automatic run_search();
    logic [LEVEL_BITS-1:0] goal;
    logic [LEVEL_BITS-1:0] lvl;
    logic [LEVEL_BITS-1:0] slack;
    logic [LEVEL_BITS:0]   sum;
    int                    pick;
    int                    steps;
    int                    burst;
    pick = $urandom_range(99);
    if (pick < 5)       goal = '0;
    else if (pick < 10) goal = LEVEL_MAX;
    else if (pick < 25) goal = LEVEL_BITS'($urandom_range(255));
    else                goal = rand_level();
    // occasional noise word of any command
    if ($urandom_range(9) == 0)
      send_word(2'($urandom), rand_level(), rand_wiper(), rand_level());
    start_search(goal, rand_wiper());
    steps = $urandom_range(12, 2);
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        burst = $urandom_range(4, 1);
        repeat (burst) report_fail();
      end else if (pick < 11) begin
        start_search(rand_level(), rand_wiper());
      end else if (pick < 13) begin
        send_word(CMD_UNUSED, rand_level(), rand_wiper(), rand_level());
      end else begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          // around the 1% window, one step past its edge included
          slack = LEVEL_BITS'($urandom_range(goal / 100 + 1));
          sum   = {1'b0, goal} + slack;
          if (slack > goal || ($urandom_range(1) == 1 && !sum[LEVEL_BITS]))
            lvl = sum[LEVEL_BITS-1:0];
          else
            lvl = goal - slack;
        end else if (pick < 35) begin
          lvl = goal;
        end else if (pick < 65) begin
          lvl = LEVEL_BITS'($urandom_range(goal, 0));
        end else begin
          lvl = LEVEL_BITS'($urandom_range(LEVEL_MAX, goal));
        end
        measure(lvl);
      end
    end
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.command        = '0;
    in_ch.target_level   = '0;
    in_ch.start_wiper    = '0;
    in_ch.measured_level = '0;
    send_pct             = 0;
    stall_pct            = 0;
    items_sent           = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part on reset register values
    set_mode(MODE_STEADY);
    // words while idle are ignored
    measure(LEVEL_MAX);
    report_fail();
    send_word(CMD_UNUSED, LEVEL_MAX, WIPER_MAX, LEVEL_MAX);
    // start at the top, then rejected start and unknown word while busy
    start_search(LEVEL_MAX, WIPER_MAX);
    start_search('0, '0);
    send_word(CMD_UNUSED, '0, '0, '0);
    measure('0);
    // failures separated by one measurement keep counting up to the stop
    report_fail();
    report_fail();
    report_fail();
    measure('0);
    report_fail();
    // a clean measurement clears the failure count
    start_search(LEVEL_BITS'(1000), WIPER_BITS'(256));
    report_fail();
    report_fail();
    report_fail();
    measure('0);
    measure('0);
    report_fail();
    measure(LEVEL_BITS'(1010));
    // unchanged wiper ends the search, with and without a tie
    start_search('0, WIPER_BITS'(256));
    measure(LEVEL_BITS'(5));
    measure(LEVEL_BITS'(3));
    start_search('0, WIPER_BITS'(256));
    measure(LEVEL_BITS'(7));
    measure(LEVEL_BITS'(7));
    // zero target met on the first measurement
    start_search('0, '0);
    measure('0);

    // random searches over register settings and idle patterns
    items_sent = 0;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      configure(seg);
      set_mode(idle_mode_t'(seg % 4));
      while (items_sent < (seg + 1) * SEGMENT_ITEMS) run_search();
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("wiper_bisection_level_calibrator verification clean");
    else
      $display("wiper_bisection_level_calibrator verification failed");
    $finish;
  end

endmodule
